// ===== hdl/aci_pkg.sv =====
// ----------------------------------------------------------------------------
// aci_pkg - shared types and constants of the CSI escape interpreter
// Character codes, action codes, parser state and result records.
// ----------------------------------------------------------------------------
package aci_pkg;

    // character codes
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_UP_A     = 8'h41;
    localparam logic [7:0] CH_UP_Z     = 8'h5A;
    localparam logic [7:0] CH_LO_A     = 8'h61;
    localparam logic [7:0] CH_LO_Z     = 8'h7A;

    // final letters
    localparam logic [7:0] CMD_UP    = 8'h41; // A
    localparam logic [7:0] CMD_DOWN  = 8'h42; // B
    localparam logic [7:0] CMD_RIGHT = 8'h43; // C
    localparam logic [7:0] CMD_LEFT  = 8'h44; // D
    localparam logic [7:0] CMD_HOME  = 8'h48; // H
    localparam logic [7:0] CMD_CLEAR = 8'h4A; // J
    localparam logic [7:0] CMD_SGR   = 8'h6D; // m

    // action codes
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_CURSOR = 2'd1;
    localparam logic [1:0] ACT_COLORS = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    // parameter values
    localparam logic [15:0] PARAM_DEFAULT = 16'd1;
    localparam logic [15:0] PARAM_CLEAR   = 16'd2;
    localparam logic [15:0] FORE_LO       = 16'd30;
    localparam logic [15:0] FORE_HI       = 16'd37;
    localparam logic [15:0] BACK_LO       = 16'd40;
    localparam logic [15:0] BACK_HI       = 16'd47;
    localparam logic [15:0] MAG_CAP       = 16'd32768;
    localparam logic [15:0] POS_MAX       = 16'd32767;

    // reset values
    localparam logic [7:0] WIDTH_RESET  = 8'd80;
    localparam logic [7:0] HEIGHT_RESET = 8'd25;
    localparam logic [3:0] FORE_RESET   = 4'd7;
    localparam logic [3:0] BACK_RESET   = 4'd0;

    // register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_SEEN = 2'd1,
        ESC_CSI  = 2'd2
    } esc_mode_t;

    typedef enum logic [2:0] {
        PH_SKIP1 = 3'd0,
        PH_NUM1  = 3'd1,
        PH_SKIP2 = 3'd2,
        PH_NUM2  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    typedef struct packed {
        esc_mode_t   esc_mode;
        phase_t      phase;
        logic        minus_seen;
        logic        digit_seen;
        logic [15:0] running_value;
        logic [15:0] first_param;
        logic [15:0] second_param;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [3:0]  fore;
        logic [3:0]  back;
    } parse_state_t;

    typedef struct packed {
        logic       consumed;
        logic [1:0] action;
        logic [7:0] cursor_col;
        logic [7:0] cursor_line;
        logic [3:0] fore_color;
        logic [3:0] back_color;
    } result_t;

endpackage

// ===== hdl/ansi_csi_escape_interpreter.sv =====
// ----------------------------------------------------------------------------
// ansi_csi_escape_interpreter - terminal escape sequence interpreter
// Follows ESC, ESC-[ and CSI parameters, tracks cursor position and colors.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one terminal byte per item in s_tdata. For every
//   byte one result item leaves on the m_ channel: consumed and action in
//   m_tuser, cursor position and colors after the byte in m_tdata.
//   The byte is held in an input register; the parser state and the result
//   register are then updated from it once the result register is free or
//   being taken, and the result shows on m_tvalid from the result register.
//   One byte per cycle is taken sustained while the receiver does not stall:
//   the whole per-byte update is one pass through the step logic.
//   When the receiver stalls, the result register and the input register
//   both hold an item before s_tready drops.
//   Screen width and height are written through cfg_we/cfg_addr/cfg_wdata
//   (index 0 width, 1 height) while no item is in flight.
//   aresetn (synchronous, active low) empties both registers, returns the
//   parser to idle, the cursor to 0,0, colors to light grey on black, and
//   the screen size to 80 by 25.
// ----------------------------------------------------------------------------
module ansi_csi_escape_interpreter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] cursor_col, [15:8] cursor_line,
                                   // [19:16] fore_color, [23:20] back_color
    output logic [2:0]  m_tuser,   // [0] consumed, [2:1] action
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    logic [7:0]            width_reg;
    logic [7:0]            height_reg;
    logic                  in_vld_reg;
    logic [7:0]            in_byte_reg;
    logic                  out_vld_reg;
    aci_pkg::result_t      out_reg;
    aci_pkg::parse_state_t state_reg;
    aci_pkg::parse_state_t state_next;
    aci_pkg::result_t      result_next;
    logic                  advance;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= aci_pkg::WIDTH_RESET;
            height_reg <= aci_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == aci_pkg::CFG_WIDTH) begin
                width_reg <= cfg_wdata;
            end else begin
                height_reg <= cfg_wdata;
            end
        end
    end

    aci_step u_step (
        .cur_state     (state_reg),
        .byte_in       (in_byte_reg),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .nxt_state     (state_next),
        .result        (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg.esc_mode      <= aci_pkg::ESC_IDLE;
            state_reg.phase         <= aci_pkg::PH_SKIP1;
            state_reg.minus_seen    <= 1'b0;
            state_reg.digit_seen    <= 1'b0;
            state_reg.running_value <= 16'd0;
            state_reg.first_param   <= aci_pkg::PARAM_DEFAULT;
            state_reg.second_param  <= aci_pkg::PARAM_DEFAULT;
            state_reg.col           <= 8'd0;
            state_reg.row           <= 8'd0;
            state_reg.fore          <= aci_pkg::FORE_RESET;
            state_reg.back          <= aci_pkg::BACK_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_reg.back_color, out_reg.fore_color,
                       out_reg.cursor_line, out_reg.cursor_col};
    assign m_tuser  = {out_reg.action, out_reg.consumed};

endmodule

// ===== hdl/aci_step.sv =====
// ----------------------------------------------------------------------------
// aci_step - next-state and result logic for one byte
// Parameter scanning, command decode and cursor/color update.
// ----------------------------------------------------------------------------
module aci_step (
    input  aci_pkg::parse_state_t cur_state,
    input  logic [7:0]            byte_in,
    input  logic [7:0]            screen_width,
    input  logic [7:0]            screen_height,
    output aci_pkg::parse_state_t nxt_state,
    output aci_pkg::result_t      result
);

    logic        is_digit;
    logic        is_blank;
    logic        is_letter;
    logic [3:0]  digit_val;
    logic [19:0] mag_x10;
    logic [15:0] mag_sat;
    logic [15:0] fin_value;
    logic [15:0] p1;
    logic [15:0] p2;
    logic        p1_pos;
    logic [15:0] row_sum;
    logic [15:0] col_sum;
    logic [15:0] fore_off;
    logic [15:0] back_off;
    logic        consumed;
    logic [1:0]  action;
    aci_pkg::parse_state_t scan;

    assign is_digit  = (byte_in >= aci_pkg::CH_ZERO) && (byte_in <= aci_pkg::CH_NINE);
    assign is_blank  = (byte_in == aci_pkg::CH_SPACE)
                    || ((byte_in >= aci_pkg::CH_TAB) && (byte_in <= aci_pkg::CH_CR));
    assign is_letter = ((byte_in >= aci_pkg::CH_UP_A) && (byte_in <= aci_pkg::CH_UP_Z))
                    || ((byte_in >= aci_pkg::CH_LO_A) && (byte_in <= aci_pkg::CH_LO_Z));
    assign digit_val = byte_in[3:0];

    // value*10 + digit, capped at the magnitude limit
    assign mag_x10 = {1'b0, cur_state.running_value, 3'b000}
                   + {3'b000, cur_state.running_value, 1'b0}
                   + {16'd0, digit_val};
    assign mag_sat = (mag_x10 > {4'd0, aci_pkg::MAG_CAP}) ? aci_pkg::MAG_CAP : mag_x10[15:0];

    // running_value never exceeds the cap, so the negative form needs no clamp
    always_comb begin
        if (cur_state.minus_seen) begin
            fin_value = 16'd0 - cur_state.running_value;
        end else if (cur_state.running_value > aci_pkg::POS_MAX) begin
            fin_value = aci_pkg::POS_MAX;
        end else begin
            fin_value = cur_state.running_value;
        end
    end

    // parameter scan
    always_comb begin
        scan = cur_state;
        unique case (cur_state.phase)
            aci_pkg::PH_SKIP1, aci_pkg::PH_SKIP2: begin
                if (!is_blank) begin
                    scan.minus_seen    = 1'b0;
                    scan.digit_seen    = 1'b0;
                    scan.running_value = 16'd0;
                    if ((byte_in == aci_pkg::CH_PLUS) || (byte_in == aci_pkg::CH_MINUS)) begin
                        scan.minus_seen = (byte_in == aci_pkg::CH_MINUS);
                        scan.phase = (cur_state.phase == aci_pkg::PH_SKIP1)
                                   ? aci_pkg::PH_NUM1 : aci_pkg::PH_NUM2;
                    end else if (is_digit) begin
                        scan.running_value = {12'd0, digit_val};
                        scan.digit_seen    = 1'b1;
                        scan.phase = (cur_state.phase == aci_pkg::PH_SKIP1)
                                   ? aci_pkg::PH_NUM1 : aci_pkg::PH_NUM2;
                    end else begin
                        scan.phase = aci_pkg::PH_DONE;
                    end
                end
            end
            aci_pkg::PH_NUM1, aci_pkg::PH_NUM2: begin
                if (is_digit) begin
                    scan.running_value = mag_sat;
                    scan.digit_seen    = 1'b1;
                end else if (!cur_state.digit_seen) begin
                    scan.phase = aci_pkg::PH_DONE;
                end else if (cur_state.phase == aci_pkg::PH_NUM1) begin
                    scan.first_param = fin_value;
                    scan.phase = (byte_in == aci_pkg::CH_SEMI)
                               ? aci_pkg::PH_SKIP2 : aci_pkg::PH_DONE;
                end else begin
                    scan.second_param = fin_value;
                    scan.phase = aci_pkg::PH_DONE;
                end
            end
            default: begin
                scan.phase = aci_pkg::PH_DONE;
            end
        endcase
    end

    // the command sees the parameters as updated by the final letter itself
    assign p1       = scan.first_param;
    assign p2       = scan.second_param;
    assign p1_pos   = !p1[15] && (p1 != 16'd0);
    assign row_sum  = {8'd0, cur_state.row} + p1;
    assign col_sum  = {8'd0, cur_state.col} + p1;
    assign fore_off = p1 - aci_pkg::FORE_LO;
    assign back_off = p1 - aci_pkg::BACK_LO;

    always_comb begin
        nxt_state = cur_state;
        consumed  = 1'b0;
        action    = aci_pkg::ACT_NONE;
        unique case (cur_state.esc_mode)
            aci_pkg::ESC_SEEN: begin
                consumed = 1'b1;
                nxt_state.esc_mode = (byte_in == aci_pkg::CH_LBRACKET)
                                   ? aci_pkg::ESC_CSI : aci_pkg::ESC_IDLE;
            end
            aci_pkg::ESC_CSI: begin
                nxt_state = scan;
                if (is_letter) begin
                    consumed = 1'b1;
                    nxt_state.esc_mode = aci_pkg::ESC_IDLE;
                    unique case (byte_in)
                        aci_pkg::CMD_UP: begin
                            action = aci_pkg::ACT_CURSOR;
                            if (p1_pos) begin
                                nxt_state.row = ({8'd0, cur_state.row} <= p1)
                                              ? 8'd0 : cur_state.row - p1[7:0];
                            end
                        end
                        aci_pkg::CMD_DOWN: begin
                            action = aci_pkg::ACT_CURSOR;
                            if (p1_pos && (({1'b0, cur_state.row} + 9'd1)
                                           < {1'b0, screen_height})) begin
                                nxt_state.row = (row_sum >= {8'd0, screen_height})
                                              ? screen_height - 8'd1 : row_sum[7:0];
                            end
                        end
                        aci_pkg::CMD_RIGHT: begin
                            action = aci_pkg::ACT_CURSOR;
                            if (p1_pos && (({1'b0, cur_state.col} + 9'd1)
                                           < {1'b0, screen_width})) begin
                                nxt_state.col = (col_sum >= {8'd0, screen_width})
                                              ? screen_width - 8'd1 : col_sum[7:0];
                            end
                        end
                        aci_pkg::CMD_LEFT: begin
                            action = aci_pkg::ACT_CURSOR;
                            if (p1_pos) begin
                                nxt_state.col = ({8'd0, cur_state.col} <= p1)
                                              ? 8'd0 : cur_state.col - p1[7:0];
                            end
                        end
                        aci_pkg::CMD_HOME: begin
                            action = aci_pkg::ACT_CURSOR;
                            nxt_state.col = p2[7:0] - 8'd1;
                            nxt_state.row = p1[7:0] - 8'd1;
                        end
                        aci_pkg::CMD_CLEAR: begin
                            action = (p1 == aci_pkg::PARAM_CLEAR)
                                   ? aci_pkg::ACT_CLEAR : aci_pkg::ACT_NONE;
                        end
                        aci_pkg::CMD_SGR: begin
                            if (p1 == 16'd0) begin
                                action = aci_pkg::ACT_COLORS;
                            end else if ((p1 >= aci_pkg::FORE_LO) && (p1 <= aci_pkg::FORE_HI)) begin
                                action = aci_pkg::ACT_COLORS;
                                nxt_state.fore = fore_off[3:0];
                            end else if ((p1 >= aci_pkg::BACK_LO) && (p1 <= aci_pkg::BACK_HI)) begin
                                action = aci_pkg::ACT_COLORS;
                                nxt_state.back = back_off[3:0];
                            end
                        end
                        default: begin
                            action = aci_pkg::ACT_NONE;
                        end
                    endcase
                end
            end
            default: begin
                if (byte_in == aci_pkg::CH_ESC) begin
                    consumed = 1'b1;
                    nxt_state.esc_mode = aci_pkg::ESC_SEEN;
                end
            end
        endcase

        // leaving CSI, or any ESC transition, starts a fresh scan
        if (consumed) begin
            nxt_state.phase         = aci_pkg::PH_SKIP1;
            nxt_state.minus_seen    = 1'b0;
            nxt_state.digit_seen    = 1'b0;
            nxt_state.running_value = 16'd0;
            nxt_state.first_param   = aci_pkg::PARAM_DEFAULT;
            nxt_state.second_param  = aci_pkg::PARAM_DEFAULT;
        end
    end

    assign result.consumed    = consumed;
    assign result.action      = action;
    assign result.cursor_col  = nxt_state.col;
    assign result.cursor_line = nxt_state.row;
    assign result.fore_color  = nxt_state.fore;
    assign result.back_color  = nxt_state.back;

endmodule
